>>> hdl/lfvp_pkg.sv
// Shared types, sizes and helpers for the LRU frame victim picker.
// No dependencies; every other file except lfvp_ram imports this package.
package lfvp_pkg;

  localparam int LINES_PER_FRAME = 4;
  localparam int FRAME_COUNT     = 16;
  localparam int STAMP_BITS      = 32;

  localparam int LINE_COUNT = LINES_PER_FRAME * FRAME_COUNT;
  localparam int LINE_AW    = $clog2(LINE_COUNT);
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int FRAME_CW   = $clog2(FRAME_COUNT + 1);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_STAMP = 2'd1,
    OP_CLEAR = 2'd2,
    OP_EVICT = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [6:0] line_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0] evict_frame;
    logic       victim_valid;
  } out_item_t;

  // classified command handed from the front to the back
  typedef struct packed {
    opcode_t              op;
    logic                 in_range;
    logic [LINE_AW-1:0]   line;
  } cmd_t;

  function automatic logic [LINE_AW-1:0] frame_base(input logic [FRAME_W-1:0] f);
    logic [LINE_AW+FRAME_W+4:0] prod;
    prod = (LINE_AW+FRAME_W+5)'(f) * (LINE_AW+FRAME_W+5)'(LINES_PER_FRAME);
    return prod[LINE_AW-1:0];
  endfunction

endpackage

>>> hdl/lfvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/lfvp_cmd_q.sv
// Short command queue between the front and the back.
// Depends on lfvp_pkg.
module lfvp_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lfvp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output lfvp_pkg::cmd_t head_cmd,
  output logic          empty
);
  import lfvp_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hdl/lfvp_front.sv
// Front end: accepts items, decodes the opcode, range-checks the line
// and queues the classified command. Depends on lfvp_pkg, lfvp_cmd_q.
module lfvp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  lfvp_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              cmd_pop,
  output lfvp_pkg::cmd_t    cmd_head,
  output logic              cmd_empty
);
  import lfvp_pkg::*;

  cmd_t cmd_new;

  always_comb begin
    cmd_new.op       = in_item.opcode;
    cmd_new.in_range = (int'(in_item.line_index) < LINE_COUNT);
    cmd_new.line     = LINE_AW'(in_item.line_index);
  end

  lfvp_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (cmd_new),
    .full     (in_full),
    .pop      (cmd_pop),
    .head_cmd (cmd_head),
    .empty    (cmd_empty)
  );

endmodule

>>> hdl/lfvp_back.sv
// Back end: use clock, stamp store (RAM plus per-line valid bits),
// evict scan and the result queue. Depends on lfvp_pkg, lfvp_ram.
module lfvp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lfvp_pkg::cmd_t     cmd_head,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output lfvp_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);
  import lfvp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t                state_r;
  logic [STAMP_BITS-1:0] use_clock_r;
  logic [LINE_COUNT-1:0] valid_r;
  logic [FRAME_CW-1:0]   iss_f_r;
  logic [FRAME_W-1:0]    pend_f_r;
  logic                  hvld_r;
  logic [STAMP_BITS-1:0] best_r;
  logic [FRAME_W-1:0]    best_f_r;

  out_item_t             res_q_r [2];
  logic                  res_wp_r;
  logic                  res_rp_r;
  logic [1:0]            res_cnt_r;

  logic                  start;
  logic                  res_push;
  out_item_t             res_new;
  logic                  res_pop;
  logic [STAMP_BITS-1:0] clock_inc;
  logic [STAMP_BITS-1:0] head_stamp;
  logic                  ram_we;
  logic [LINE_AW-1:0]    ram_waddr;
  logic [STAMP_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [LINE_AW-1:0]    ram_raddr;
  logic [STAMP_BITS-1:0] ram_rdata;
  logic                  scan_more;
  logic [LINE_AW-1:0]    fin_base;

  // the result slot is reserved when a command starts
  assign start     = (state_r == ST_IDLE) && !cmd_empty && (res_cnt_r != 2'd2);
  assign cmd_pop   = start;
  assign clock_inc = (use_clock_r == '1) ? use_clock_r : use_clock_r + 1'b1;
  assign head_stamp = hvld_r ? ram_rdata : '0;
  assign scan_more = (iss_f_r < FRAME_CW'(FRAME_COUNT));
  assign fin_base  = frame_base(best_f_r);
  assign res_pop   = out_pop && !out_empty;
  assign out_empty = (res_cnt_r == 2'd0);
  assign out_item  = res_q_r[res_rp_r];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_head.line;
    ram_wdata = use_clock_r;
    ram_re    = 1'b0;
    ram_raddr = frame_base('0);
    res_push  = 1'b0;
    res_new   = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd_head.op)
            OP_TOUCH: begin
              ram_we    = cmd_head.in_range;
              ram_wdata = clock_inc;
              res_push  = 1'b1;
            end
            OP_STAMP: begin
              ram_we   = cmd_head.in_range;
              res_push = 1'b1;
            end
            OP_CLEAR: begin
              res_push = 1'b1;
            end
            default: begin
              ram_re = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re    = scan_more;
        ram_raddr = frame_base(iss_f_r[FRAME_W-1:0]);
      end
      ST_FIN: begin
        res_push             = 1'b1;
        res_new.evict_frame  = 4'(best_f_r);
        res_new.victim_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wp_r] <= res_new;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      use_clock_r <= '0;
      valid_r     <= '0;
      res_wp_r    <= 1'b0;
      res_rp_r    <= 1'b0;
      res_cnt_r   <= 2'd0;
      iss_f_r     <= '0;
      pend_f_r    <= '0;
      hvld_r      <= 1'b0;
      best_r      <= '0;
      best_f_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            case (cmd_head.op)
              OP_TOUCH: begin
                use_clock_r <= clock_inc;
                if (cmd_head.in_range) begin
                  valid_r[cmd_head.line] <= 1'b1;
                end
              end
              OP_STAMP: begin
                if (cmd_head.in_range) begin
                  valid_r[cmd_head.line] <= 1'b1;
                end
              end
              OP_CLEAR: begin
                if (cmd_head.in_range) begin
                  valid_r[cmd_head.line] <= 1'b0;
                end
              end
              default: begin
                hvld_r   <= valid_r[ram_raddr];
                pend_f_r <= '0;
                iss_f_r  <= FRAME_CW'(1);
                state_r  <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // strict compare keeps the lowest frame on ties
          if (pend_f_r == '0 || head_stamp < best_r) begin
            best_r   <= head_stamp;
            best_f_r <= pend_f_r;
          end
          if (scan_more) begin
            hvld_r   <= valid_r[ram_raddr];
            pend_f_r <= iss_f_r[FRAME_W-1:0];
            iss_f_r  <= iss_f_r + 1'b1;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int k = 0; k < LINES_PER_FRAME; k++) begin
            valid_r[fin_base + LINE_AW'(k)] <= 1'b0;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (res_push) begin
        res_wp_r <= !res_wp_r;
      end
      if (res_pop) begin
        res_rp_r <= !res_rp_r;
      end
      case ({res_push, res_pop})
        2'b10:   res_cnt_r <= res_cnt_r + 1'b1;
        2'b01:   res_cnt_r <= res_cnt_r - 1'b1;
        default: res_cnt_r <= res_cnt_r;
      endcase
    end
  end

  lfvp_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (LINE_COUNT)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hdl/lru_frame_victim_picker.sv
// LRU frame victim picker. Touch, stamp and clear each complete as the
// command is taken from the queue; evict scans the frame-head stamps
// serially through the single read port of the stamp RAM.
// A 4-deep command queue decouples intake from execution. Synchronous
// active-low reset empties both queues, zeroes the use clock and marks
// every stamp as zero at once.
module lru_frame_victim_picker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  lfvp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output lfvp_pkg::out_item_t out_item
);
  import lfvp_pkg::*;

  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  lfvp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty)
  );

  lfvp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

>>> hdl/lfvp_checker.sv
// Port-level checks for the LRU frame victim picker, bound to the top level.
// Depends on lfvp_pkg.
module lfvp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input lfvp_pkg::in_item_t  in_item,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input lfvp_pkg::out_item_t out_item
);
  import lfvp_pkg::*;

  logic [3:0] outstanding_r;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_r + 4'(acc_in) - 4'(acc_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> outstanding_r != 4'd0)
    else $error("result shown with no item outstanding");

  a_non_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.victim_valid) |-> out_item.evict_frame == 4'd0)
    else $error("non-evict result carries a frame number");

  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.victim_valid) |-> int'(out_item.evict_frame) < FRAME_COUNT)
    else $error("victim frame out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind lru_frame_victim_picker lfvp_checker u_lfvp_checker (.*);
